### hw/rtl/mcs_pkg.sv
// shared types, constants and helpers for the momentum crossover signal block
package mcs_pkg;

    localparam int HIST_DEPTH = 64;
    localparam int PTR_W      = $clog2(HIST_DEPTH);
    localparam int PERIOD_MAX = 64;
    localparam int PERIOD_CAP = (PERIOD_MAX < HIST_DEPTH) ? PERIOD_MAX : HIST_DEPTH;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam int PRICE_W    = 32;
    localparam int THR_W      = 16;
    localparam int SUM_W      = 38;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int Q_SHIFT    = 16;

    localparam logic [CNT_W-1:0] AVG_SAT = CNT_W'(PERIOD_MAX);
    localparam logic [CNT_W-1:0] SES_SAT = CNT_W'(PERIOD_MAX + 1);

    localparam logic KIND_PRICE   = 1'b0;
    localparam logic KIND_SESSION = 1'b1;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } sig_code_t;

    typedef enum logic [2:0] {
        REG_SHORT_PERIOD  = 3'd0,
        REG_LONG_PERIOD   = 3'd1,
        REG_THRESHOLD     = 3'd2,
        REG_POSITION_SIZE = 3'd3,
        REG_MAX_POSITION  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               kind;
        logic [PRICE_W-1:0] price;
    } in_item_t;

    typedef struct packed {
        sig_code_t signal;
        logic      holding;
    } out_item_t;

    // history read addresses and the data they return
    typedef struct packed {
        logic [PTR_W-1:0] drop_short;
        logic [PTR_W-1:0] drop_long;
        logic [PTR_W-1:0] old;
    } hist_addr_t;

    typedef struct packed {
        logic [PRICE_W-1:0] drop_short;
        logic [PRICE_W-1:0] drop_long;
        logic [PRICE_W-1:0] old;
    } hist_data_t;

    function automatic logic [CNT_W-1:0] clamp_period(input logic [CNT_W-1:0] p);
        logic [CNT_W-1:0] res;
        res = p;
        if (p == '0) begin
            res = CNT_W'(1);
        end else if (p > CNT_W'(PERIOD_CAP)) begin
            res = CNT_W'(PERIOD_CAP);
        end
        return res;
    endfunction

    // ring slot n places before wp, n never exceeds the depth
    function automatic logic [PTR_W-1:0] idx_back(input logic [PTR_W-1:0] wp,
                                                  input logic [CNT_W-1:0] n);
        logic [IDX_W-1:0] w;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] res;
        w = IDX_W'(wp);
        k = IDX_W'(n);
        if (w >= k) begin
            res = w - k;
        end else begin
            res = w + IDX_W'(HIST_DEPTH) - k;
        end
        return res[PTR_W-1:0];
    endfunction

endpackage

### hw/rtl/momentum_crossover_signal.sv
// top level of the momentum crossover signal block
//
// Input channel s_*: one beat is a price (kind 0) or a session reset (kind 1).
// Result channel m_*: exactly one beat per input beat, in order, carrying
// the buy/sell/none code and whether a position is open afterwards.
// Throughput is one beat per cycle while m_ready is high and no rebuild runs.
// A beat accepted at one edge is read from the history ring at that edge,
// evaluated in the next cycle, and its result is registered in the output
// register once that register is free. The short and long sums are kept as
// sliding sums: each price adds itself and subtracts the price leaving each window.
// Writing short_period or long_period starts a rebuild of both sums from the
// ring: s_ready stays low while the rebuild runs.
// Registers sit on the APB port at byte offsets 0, 4, 8, 12, 16; pready is
// always high. Reset clears the ring, the sums, the counters and the open
// position and loads the register defaults. When the receiver stalls, one
// result waits in the output register and one item in the input register,
// after which s_ready drops until m_ready returns.
module momentum_crossover_signal import mcs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration
    logic [CNT_W-1:0]   short_period_reg;
    logic [CNT_W-1:0]   long_period_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic [PRICE_W-1:0] position_size_reg;
    logic [PRICE_W-1:0] max_position_reg;

    logic     cfg_wr;
    logic     period_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign period_wr = cfg_wr &&
                       (cfg_idx == REG_SHORT_PERIOD || cfg_idx == REG_LONG_PERIOD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_period_reg  <= CNT_W'(5);
            long_period_reg   <= CNT_W'(10);
            threshold_reg     <= THR_W'(1311);
            position_size_reg <= PRICE_W'(1000);
            max_position_reg  <= PRICE_W'(5000);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SHORT_PERIOD:  short_period_reg  <= pwdata[CNT_W-1:0];
                REG_LONG_PERIOD:   long_period_reg   <= pwdata[CNT_W-1:0];
                REG_THRESHOLD:     threshold_reg     <= pwdata[THR_W-1:0];
                REG_POSITION_SIZE: position_size_reg <= pwdata[PRICE_W-1:0];
                REG_MAX_POSITION:  max_position_reg  <= pwdata[PRICE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SHORT_PERIOD:  prdata = DATA_W'(short_period_reg);
            REG_LONG_PERIOD:   prdata = DATA_W'(long_period_reg);
            REG_THRESHOLD:     prdata = DATA_W'(threshold_reg);
            REG_POSITION_SIZE: prdata = DATA_W'(position_size_reg);
            REG_MAX_POSITION:  prdata = DATA_W'(max_position_reg);
            default:           prdata = '0;
        endcase
    end

    logic [CNT_W-1:0] sp;
    logic [CNT_W-1:0] lp;

    assign sp = clamp_period(short_period_reg);
    assign lp = clamp_period(long_period_reg);

    // handshake and pipeline control
    logic             st1_valid_reg;
    in_item_t         st1_item_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;
    logic             sweep_run_reg;
    logic [CNT_W-1:0] sweep_cnt_reg;
    logic             acc_valid_reg;
    logic [CNT_W-1:0] acc_idx_reg;
    logic             busy;
    logic             adv;
    logic             s_accept;

    assign busy     = sweep_run_reg || acc_valid_reg;
    assign adv      = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !busy && (!st1_valid_reg || adv);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // history ring
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic             hist_wr;
    logic             hist_rd;
    hist_addr_t       hist_addr;
    hist_data_t       hist_data;

    assign hist_wr = s_accept && (s_data.kind == KIND_PRICE);
    assign hist_rd = s_accept || sweep_run_reg;

    always_comb begin
        hist_addr.drop_short = idx_back(wp_reg, sp);
        hist_addr.drop_long  = idx_back(wp_reg, lp);
        if (sweep_run_reg) begin
            hist_addr.old = idx_back(wp_reg, sweep_cnt_reg + CNT_W'(1));
        end else begin
            hist_addr.old = idx_back(wp_reg, sp - CNT_W'(1));
        end
    end

    always_comb begin
        wp_next = wp_reg;
        if (hist_wr) begin
            wp_next = (wp_reg == PTR_W'(HIST_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
        end
    end

    mcs_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (hist_wr),
        .wr_addr (wp_reg),
        .wr_data (s_data.price),
        .rd_en   (hist_rd),
        .rd_addr (hist_addr),
        .rd_data (hist_data)
    );

    // evaluation of the item in the input register
    logic [SUM_W-1:0]     short_sum_reg;
    logic [SUM_W-1:0]     long_sum_reg;
    logic [SUM_W-1:0]     short_sum_next;
    logic [SUM_W-1:0]     long_sum_next;
    logic [CNT_W-1:0]     avg_cnt_reg;
    logic [CNT_W-1:0]     ses_cnt_reg;
    logic [CNT_W-1:0]     avg_cnt_next;
    logic [CNT_W-1:0]     ses_cnt_next;
    logic                 pos_reg;
    logic                 pos_next;
    out_item_t            result;

    logic [SUM_W-1:0]     short_upd;
    logic [SUM_W-1:0]     long_upd;
    logic [CNT_W-1:0]     avg_inc;
    logic [CNT_W-1:0]     ses_inc;
    logic [PRICE_W-1:0]   old_price;
    logic [THR_W:0]       thr_up;
    logic [THR_W:0]       thr_dn;
    logic [PRICE_W+THR_W:0] cur_q;
    logic [PRICE_W+THR_W:0] up_rhs;
    logic [PRICE_W+THR_W:0] dn_rhs;
    logic [SUM_W+CNT_W-1:0] avg_lhs;
    logic [SUM_W+CNT_W-1:0] avg_rhs;
    logic                 mom_up;
    logic                 mom_dn;
    logic                 win_full;
    logic                 armed;
    logic                 buy;
    logic                 sell;

    always_comb begin
        short_upd = short_sum_reg + SUM_W'(st1_item_reg.price) -
                    SUM_W'(hist_data.drop_short);
        long_upd  = long_sum_reg + SUM_W'(st1_item_reg.price) -
                    SUM_W'(hist_data.drop_long);
        avg_inc   = (avg_cnt_reg < AVG_SAT) ? avg_cnt_reg + CNT_W'(1) : avg_cnt_reg;
        ses_inc   = (ses_cnt_reg < SES_SAT) ? ses_cnt_reg + CNT_W'(1) : ses_cnt_reg;
        // with a unit lookback the earlier price is the new price itself
        old_price = (sp == CNT_W'(1)) ? st1_item_reg.price : hist_data.old;
        thr_up    = (THR_W+1)'(1 << Q_SHIFT) + (THR_W+1)'(threshold_reg);
        thr_dn    = (THR_W+1)'(1 << Q_SHIFT) - (THR_W+1)'(threshold_reg);
        cur_q     = {1'b0, st1_item_reg.price, {Q_SHIFT{1'b0}}};
        up_rhs    = (PRICE_W+THR_W+1)'(old_price) * (PRICE_W+THR_W+1)'(thr_up);
        dn_rhs    = (PRICE_W+THR_W+1)'(old_price) * (PRICE_W+THR_W+1)'(thr_dn);
        avg_lhs   = (SUM_W+CNT_W)'(short_upd) * (SUM_W+CNT_W)'(lp);
        avg_rhs   = (SUM_W+CNT_W)'(long_upd) * (SUM_W+CNT_W)'(sp);
        mom_up    = cur_q > up_rhs;
        mom_dn    = cur_q < dn_rhs;
        win_full  = (avg_inc >= sp) && (avg_inc >= lp);
        armed     = (ses_inc > sp) && (old_price != '0);
        buy       = armed && mom_up && !pos_reg && win_full &&
                    (avg_lhs > avg_rhs) && (position_size_reg <= max_position_reg);
        sell      = armed && mom_dn && pos_reg;
    end

    always_comb begin
        avg_cnt_next   = avg_cnt_reg;
        ses_cnt_next   = ses_cnt_reg;
        pos_next       = pos_reg;
        result.signal  = SIG_NONE;
        if (st1_item_reg.kind == KIND_SESSION) begin
            ses_cnt_next = '0;
            pos_next     = 1'b0;
        end else begin
            avg_cnt_next = avg_inc;
            ses_cnt_next = ses_inc;
            if (buy) begin
                pos_next      = 1'b1;
                result.signal = SIG_BUY;
            end else if (sell) begin
                pos_next      = 1'b0;
                result.signal = SIG_SELL;
            end
        end
        result.holding = pos_next;
    end

    // sums: slid by each accepted price, cleared and rebuilt from the ring after a period write
    always_comb begin
        short_sum_next = short_sum_reg;
        long_sum_next  = long_sum_reg;
        if (period_wr) begin
            short_sum_next = '0;
            long_sum_next  = '0;
        end else if (acc_valid_reg) begin
            if (acc_idx_reg < sp) begin
                short_sum_next = short_sum_reg + SUM_W'(hist_data.old);
            end
            if (acc_idx_reg < lp) begin
                long_sum_next = long_sum_reg + SUM_W'(hist_data.old);
            end
        end else if (adv && st1_item_reg.kind == KIND_PRICE) begin
            short_sum_next = short_upd;
            long_sum_next  = long_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_run_reg <= 1'b0;
            sweep_cnt_reg <= '0;
            acc_valid_reg <= 1'b0;
            acc_idx_reg   <= '0;
        end else if (period_wr) begin
            sweep_run_reg <= 1'b1;
            sweep_cnt_reg <= '0;
            acc_valid_reg <= 1'b0;
        end else if (sweep_run_reg) begin
            acc_valid_reg <= 1'b1;
            acc_idx_reg   <= sweep_cnt_reg;
            if (sweep_cnt_reg == CNT_W'(PERIOD_CAP - 1)) begin
                sweep_run_reg <= 1'b0;
            end else begin
                sweep_cnt_reg <= sweep_cnt_reg + CNT_W'(1);
            end
        end else begin
            acc_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
            avg_cnt_reg   <= '0;
            ses_cnt_reg   <= '0;
            pos_reg       <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            short_sum_reg <= short_sum_next;
            long_sum_reg  <= long_sum_next;
            if (adv) begin
                avg_cnt_reg <= avg_cnt_next;
                ses_cnt_reg <= ses_cnt_next;
                pos_reg     <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                st1_valid_reg <= 1'b1;
            end else if (adv) begin
                st1_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_item_reg <= s_data;
        end
        if (adv) begin
            m_data_reg <= result;
        end
    end

endmodule

### hw/rtl/mcs_hist.sv
// price history ring: two copies give three read ports, valid bits make unwritten slots read zero
module mcs_hist import mcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [PTR_W-1:0]   wr_addr,
    input  logic [PRICE_W-1:0] wr_data,
    input  logic               rd_en,
    input  hist_addr_t         rd_addr,
    output hist_data_t         rd_data
);

    logic [PRICE_W-1:0]    mem_a [HIST_DEPTH];
    logic [PRICE_W-1:0]    mem_b [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] vld_reg;
    hist_data_t            rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // reads see the contents before this edge's write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg.drop_short <= vld_reg[rd_addr.drop_short] ?
                                      mem_a[rd_addr.drop_short] : '0;
            rd_data_reg.old        <= vld_reg[rd_addr.old] ? mem_a[rd_addr.old] : '0;
            rd_data_reg.drop_long  <= vld_reg[rd_addr.drop_long] ?
                                      mem_b[rd_addr.drop_long] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
